@@ design/mkcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Multi-key click classifier package
// Shared widths, key status codes, register indexes and the threshold record.
// ----------------------------------------------------------------------------
`default_nettype none

package mkcc_pkg;

  localparam int PIN_W    = 4;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 16;
  localparam int EVENT_W  = 3;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_STATUS_OUT = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_RELEASED = 2'd0,
    ST_PRESS    = 2'd1,
    ST_LONG     = 2'd2,
    ST_DOUBLE   = 2'd3
  } key_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_PRESS_MIN = 2'd0,
    REG_LONG_PRESS_MIN  = 2'd1,
    REG_DOUBLE_GAP_MAX  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_W-1:0] short_press_min;
    logic [THR_W-1:0] long_press_min;
    logic [THR_W-1:0] double_gap_max;
  } thresholds_t;

  localparam logic [THR_W-1:0] SHORT_PRESS_MIN_RST = 16'd20;
  localparam logic [THR_W-1:0] LONG_PRESS_MIN_RST  = 16'd1000;
  localparam logic [THR_W-1:0] DOUBLE_GAP_MAX_RST  = 16'd300;

endpackage

`default_nettype wire

@@ design/mkcc_ifs.sv @@
// ----------------------------------------------------------------------------
// Multi-key click classifier channels
// Poll input, result output and threshold write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkcc_poll_if import mkcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIN_W-1:0]  pins_low;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output pins_low, output now_ms, input ready);
  modport sink   (input valid, input pins_low, input now_ms, output ready);
endinterface

interface mkcc_result_if import mkcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [EVENT_W-1:0]  event_key;
  logic [STATUS_W-1:0] key0_status;
  logic [STATUS_W-1:0] key1_status;
  logic [STATUS_W-1:0] key2_status;
  logic [STATUS_W-1:0] key3_status;

  modport source (output valid, output event_key, output key0_status,
                  output key1_status, output key2_status, output key3_status,
                  input ready);
  modport sink   (input valid, input event_key, input key0_status,
                  input key1_status, input key2_status, input key3_status,
                  output ready);
endinterface

interface mkcc_cfg_if import mkcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [THR_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/mkcc_key.sv @@
// ----------------------------------------------------------------------------
// Key tracker
// Holds the state of one key and computes its status for the current poll.
// ----------------------------------------------------------------------------
`default_nettype none

module mkcc_key import mkcc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              down,
  input  wire logic [TIME_W-1:0] now,
  input  wire thresholds_t       thr,
  input  wire logic              clear,
  output key_status_t            status_upd
);

  logic              held;
  logic              pending;
  logic [TIME_W-1:0] press_time;
  logic [TIME_W-1:0] release_time;
  key_status_t       status;

  logic              held_next;
  logic              pending_next;
  logic [TIME_W-1:0] press_time_next;
  logic [TIME_W-1:0] release_time_next;

  logic [TIME_W-1:0] hold_len;
  logic [TIME_W-1:0] gap_len;
  logic              gap_over;
  logic              long_reached;
  logic              click_ok;

  assign hold_len     = now - press_time;
  assign gap_len      = now - release_time;
  assign gap_over     = gap_len > {{(TIME_W-THR_W){1'b0}}, thr.double_gap_max};
  assign long_reached = hold_len >= {{(TIME_W-THR_W){1'b0}}, thr.long_press_min};
  assign click_ok     = (hold_len >= {{(TIME_W-THR_W){1'b0}}, thr.short_press_min})
                        && !long_reached;

  always_comb begin
    held_next         = held;
    pending_next      = pending;
    press_time_next   = press_time;
    release_time_next = release_time;
    status_upd        = status;
    if (pending && gap_over) begin
      pending_next = 1'b0;
      status_upd   = ST_PRESS;
    end
    if (down) begin
      if (!held) begin
        held_next       = 1'b1;
        press_time_next = now;
      end else if (long_reached) begin
        status_upd = ST_LONG;
      end
    end else if (held) begin
      if (click_ok) begin
        if (!pending_next) begin
          release_time_next = now;
          pending_next      = 1'b1;
        end else begin
          if (!gap_over) begin
            status_upd = ST_DOUBLE;
          end
          pending_next = 1'b0;
        end
      end
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= 1'b0;
      pending      <= 1'b0;
      press_time   <= '0;
      release_time <= '0;
      status       <= ST_RELEASED;
    end else if (en) begin
      held         <= held_next;
      pending      <= pending_next;
      press_time   <= press_time_next;
      release_time <= release_time_next;
      status       <= clear ? ST_RELEASED : status_upd;
    end
  end

endmodule

`default_nettype wire

@@ design/mkcc_pick.sv @@
// ----------------------------------------------------------------------------
// Single press picker
// Finds the lowest-numbered key in single press and marks it to be consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module mkcc_pick import mkcc_pkg::*; #(
  parameter int NUM_KEYS = 4
) (
  input  key_status_t              status_upd [NUM_KEYS],
  output logic [NUM_KEYS-1:0]      clear,
  output logic [EVENT_W-1:0]       event_key
);

  always_comb begin
    logic found;
    found     = 1'b0;
    clear     = '0;
    event_key = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (!found && status_upd[k] == ST_PRESS) begin
        found     = 1'b1;
        clear[k]  = 1'b1;
        event_key = EVENT_W'(k + 1);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/multi_key_click_classifier_core.sv @@
// ----------------------------------------------------------------------------
// Multi-key click classifier core
// Classifies clicks, double clicks and long presses on a bank of keys.
// ----------------------------------------------------------------------------
// A poll transfer is captured in the poll input register and its result in the result register.
// Throughput: one poll per cycle while the result side takes results; the poll input register and the result
// register decouple the two channels.
// Reset clears all key state to released and loads the thresholds with
// 20 ms, 1000 ms and 300 ms.
`default_nettype none

module multi_key_click_classifier_core import mkcc_pkg::*; #(
  parameter int NUM_KEYS = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  mkcc_poll_if.sink     poll,
  mkcc_result_if.source result,
  mkcc_cfg_if.sink      cfg
);

  thresholds_t       thr;

  logic              s1_valid;
  logic [PIN_W-1:0]  s1_pins;
  logic [TIME_W-1:0] s1_now;
  logic              advance;

  logic [NUM_KEYS-1:0] down;
  logic [NUM_KEYS-1:0] clear;
  key_status_t         status_upd [NUM_KEYS];
  key_status_t         status_fin [NUM_KEYS];
  logic [EVENT_W-1:0]  event_key;
  key_status_t         status_out [NUM_STATUS_OUT];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.short_press_min <= SHORT_PRESS_MIN_RST;
      thr.long_press_min  <= LONG_PRESS_MIN_RST;
      thr.double_gap_max  <= DOUBLE_GAP_MAX_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SHORT_PRESS_MIN: thr.short_press_min <= cfg.data;
        REG_LONG_PRESS_MIN:  thr.long_press_min  <= cfg.data;
        REG_DOUBLE_GAP_MAX:  thr.double_gap_max  <= cfg.data;
        default: ;
      endcase
    end
  end

  assign advance    = s1_valid && (!result.valid || result.ready);
  assign poll.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_pins <= poll.pins_low;
      s1_now  <= poll.now_ms;
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    if (k < PIN_W) begin : g_pin
      assign down[k] = s1_pins[k];
    end else begin : g_nopin
      assign down[k] = 1'b0;
    end

    mkcc_key u_key (
      .clk        (clk),
      .rst        (rst),
      .en         (advance),
      .down       (down[k]),
      .now        (s1_now),
      .thr        (thr),
      .clear      (clear[k]),
      .status_upd (status_upd[k])
    );

    assign status_fin[k] = clear[k] ? ST_RELEASED : status_upd[k];
  end

  mkcc_pick #(
    .NUM_KEYS (NUM_KEYS)
  ) u_pick (
    .status_upd (status_upd),
    .clear      (clear),
    .event_key  (event_key)
  );

  for (genvar i = 0; i < NUM_STATUS_OUT; i++) begin : g_out
    if (i < NUM_KEYS) begin : g_have
      assign status_out[i] = status_fin[i];
    end else begin : g_none
      assign status_out[i] = ST_RELEASED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.event_key   <= event_key;
      result.key0_status <= status_out[0];
      result.key1_status <= status_out[1];
      result.key2_status <= status_out[2];
      result.key3_status <= status_out[3];
    end
  end

  // With no event reported, no visible key may still be in single press.
  a_no_event_no_press: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.event_key == '0 |->
      result.key0_status != ST_PRESS && result.key1_status != ST_PRESS &&
      result.key2_status != ST_PRESS && result.key3_status != ST_PRESS)
    else $error("unreported single press on a status output");

  // A reported key 0 has been consumed back to released.
  a_event_consumed: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.event_key == EVENT_W'(1) |->
      result.key0_status == ST_RELEASED)
    else $error("reported key was not consumed");

  // A poll waiting in the input register is neither lost nor overwritten.
  a_poll_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_now) && $stable(s1_pins))
    else $error("stalled poll was lost or overwritten");

endmodule

`default_nettype wire

@@ bench/tb_multi_key_click_classifier_core.sv @@
// ----------------------------------------------------------------------------
// Multi-key click classifier core testbench
// Drives polls through a directed table and then through random phases that
// each load a new set of thresholds. The poll and result channels idle and
// stall at random, and once the result side holds off for a long stretch.
// Every result transfer is checked against a cycle-free model of the
// classifier that runs on each poll transfer, or against the typed row's expected value.
// ----------------------------------------------------------------------------
module tb_multi_key_click_classifier_core import mkcc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEYS            = 4;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_SHOWN       = 10;
  localparam int PHASES          = 7;
  localparam int PHASE_POLLS     = 100;

  typedef struct packed {
    logic [EVENT_W-1:0]                        event_key;
    logic [NUM_STATUS_OUT-1:0][STATUS_W-1:0]   status;
  } poll_result_t;

  typedef struct packed {
    bit           typed;
    poll_result_t want;
  } typed_note_t;

  typedef enum logic {ROW_POLL, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [PIN_W-1:0]  pins;
    logic [TIME_W-1:0] now;
    cfg_reg_t          idx;
    logic [THR_W-1:0]  value;
    bit                typed;
    poll_result_t      want;
  } stim_row_t;

  logic clk;
  logic rst;

  mkcc_poll_if   poll_ch ();
  mkcc_result_if res_ch ();
  mkcc_cfg_if    cfg_ch ();

  multi_key_click_classifier_core u_top (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Classifier model state.
  logic              held     [KEYS];
  logic              pend     [KEYS];
  logic [TIME_W-1:0] press_at [KEYS];
  logic [TIME_W-1:0] release_at [KEYS];
  key_status_t       kst      [KEYS];
  thresholds_t       thr;

  poll_result_t poll_outcomes [$];
  typed_note_t  typed_outcomes [$];
  stim_row_t    dir_rows [$];

  int mismatches = 0;
  int cycles = 0;
  bit burst = 1'b0;
  bit hold_off_req = 1'b0;

  typed_note_t  note_m;
  poll_result_t outcome_m;
  poll_result_t seen_m;
  poll_result_t want_m;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic poll_result_t classify_poll(input logic [PIN_W-1:0] pins,
                                                 input logic [TIME_W-1:0] now);
    poll_result_t      r;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] short_min;
    logic [TIME_W-1:0] long_min;
    logic [TIME_W-1:0] gap_max;
    bit                found;
    short_min = {16'd0, thr.short_press_min};
    long_min  = {16'd0, thr.long_press_min};
    gap_max   = {16'd0, thr.double_gap_max};
    r = '0;
    found = 1'b0;
    for (int k = 0; k < KEYS; k++) begin
      gap = now - release_at[k];
      if (pend[k] && gap > gap_max) begin
        pend[k] = 1'b0;
        kst[k] = ST_PRESS;
      end
      span = now - press_at[k];
      if (pins[k]) begin
        if (!held[k]) begin
          held[k] = 1'b1;
          press_at[k] = now;
        end else if (span >= long_min) begin
          kst[k] = ST_LONG;
        end
      end else if (held[k]) begin
        if (span >= short_min && span < long_min) begin
          if (!pend[k]) begin
            release_at[k] = now;
            pend[k] = 1'b1;
          end else begin
            gap = now - release_at[k];
            if (gap <= gap_max) kst[k] = ST_DOUBLE;
            pend[k] = 1'b0;
          end
        end
        held[k] = 1'b0;
      end
    end
    for (int k = 0; k < KEYS; k++) begin
      if (!found && kst[k] == ST_PRESS) begin
        r.event_key = EVENT_W'(k + 1);
        kst[k] = ST_RELEASED;
        found = 1'b1;
      end
    end
    for (int k = 0; k < KEYS; k++) r.status[k] = kst[k];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      thr.short_press_min = SHORT_PRESS_MIN_RST;
      thr.long_press_min  = LONG_PRESS_MIN_RST;
      thr.double_gap_max  = DOUBLE_GAP_MAX_RST;
      for (int k = 0; k < KEYS; k++) begin
        held[k] = 1'b0;
        pend[k] = 1'b0;
        press_at[k] = '0;
        release_at[k] = '0;
        kst[k] = ST_RELEASED;
      end
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_SHORT_PRESS_MIN: thr.short_press_min = cfg_ch.data;
          REG_LONG_PRESS_MIN:  thr.long_press_min  = cfg_ch.data;
          REG_DOUBLE_GAP_MAX:  thr.double_gap_max  = cfg_ch.data;
          default: ;
        endcase
      end
      if (poll_ch.valid && poll_ch.ready) begin
        note_m = '0;
        if (typed_outcomes.size() != 0) note_m = typed_outcomes.pop_front();
        outcome_m = classify_poll(poll_ch.pins_low, poll_ch.now_ms);
        poll_outcomes.push_back(note_m.typed ? note_m.want : outcome_m);
      end
      if (res_ch.valid && res_ch.ready) begin
        seen_m = {res_ch.event_key, res_ch.key3_status, res_ch.key2_status,
                  res_ch.key1_status, res_ch.key0_status};
        if (poll_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result transfer: event_key %0d", seen_m.event_key);
        end else begin
          want_m = poll_outcomes.pop_front();
          if (seen_m !== want_m) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("result mismatch (expected/actual): event_key %0d/%0d key0 %0d/%0d %s",
                       want_m.event_key, seen_m.event_key,
                       want_m.status[0], seen_m.status[0],
                       $sformatf("key1 %0d/%0d key2 %0d/%0d key3 %0d/%0d",
                                 want_m.status[1], seen_m.status[1],
                                 want_m.status[2], seen_m.status[2],
                                 want_m.status[3], seen_m.status[3]));
          end
        end
      end
    end
  end

  // Result side: segments of steady, random and stalled ready.
  initial begin
    int mode;
    int seg_len;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_CYCLES) begin
          res_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        mode = $urandom_range(0, 9);
        seg_len = $urandom_range(4, 40);
        repeat (seg_len) begin
          case (mode)
            0, 1, 2: res_ch.ready <= 1'b1;
            3, 4, 5: res_ch.ready <= 1'($urandom_range(0, 1));
            6, 7:    res_ch.ready <= ($urandom_range(0, 3) != 0);
            8:       res_ch.ready <= ($urandom_range(0, 3) == 0);
            default: res_ch.ready <= 1'b0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic void add_poll(input logic [PIN_W-1:0] pins,
                                   input logic [TIME_W-1:0] now,
                                   input bit typed = 1'b0,
                                   input poll_result_t want = '0);
    stim_row_t r;
    r.kind = ROW_POLL;
    r.pins = pins;
    r.now = now;
    r.idx = REG_SHORT_PRESS_MIN;
    r.value = '0;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input cfg_reg_t idx, input logic [THR_W-1:0] value);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.pins = '0;
    r.now = '0;
    r.idx = idx;
    r.value = value;
    r.typed = 1'b0;
    r.want = '0;
    dir_rows.push_back(r);
  endfunction

  task automatic send_poll(input logic [PIN_W-1:0] pins, input logic [TIME_W-1:0] now,
                           input bit typed, input poll_result_t want);
    int gap;
    int r;
    gap = 0;
    if (!burst) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(8, 30);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_outcomes.push_back({typed, want});
    poll_ch.valid <= 1'b1;
    poll_ch.pins_low <= pins;
    poll_ch.now_ms <= now;
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    poll_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (poll_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [THR_W-1:0] value);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [PIN_W-1:0]  pins;
    logic [TIME_W-1:0] now;
    int span;
    int sel;
    int sh;
    int lo;
    int gp;
    poll_ch.valid <= 1'b0;
    poll_ch.pins_low <= '0;
    poll_ch.now_ms <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_SHORT_PRESS_MIN;
    cfg_ch.data <= '0;
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset state, then all keys held across the timestamp wrap into a long press.
    add_poll(4'h0, 32'd0, 1'b1, {3'd0, ST_RELEASED, ST_RELEASED, ST_RELEASED, ST_RELEASED});
    add_poll(4'hF, 32'hFFFF_FFFF, 1'b1,
             {3'd0, ST_RELEASED, ST_RELEASED, ST_RELEASED, ST_RELEASED});
    add_poll(4'hF, 32'd999, 1'b1, {3'd0, ST_LONG, ST_LONG, ST_LONG, ST_LONG});
    add_poll(4'h0, 32'd1010, 1'b1, {3'd0, ST_LONG, ST_LONG, ST_LONG, ST_LONG});
    // Single click on key 0 that times out.
    add_poll(4'h1, 32'd2000);
    add_poll(4'h0, 32'd2050);
    add_poll(4'h0, 32'd2400);
    // Double click on key 1.
    add_poll(4'h2, 32'd3000);
    add_poll(4'h0, 32'd3030);
    add_poll(4'h2, 32'd3100);
    add_poll(4'h0, 32'd3150);
    // Too short on key 2, too long on key 3.
    add_poll(4'h4, 32'd4000);
    add_poll(4'h0, 32'd4005);
    add_poll(4'h8, 32'd4100);
    add_poll(4'h0, 32'd5600);
    // Keys 2 and 3 time out together; the lower key is reported first.
    add_poll(4'hC, 32'd6000);
    add_poll(4'h0, 32'd6100);
    add_poll(4'h0, 32'd6500);
    add_poll(4'h0, 32'd6501);
    // Second click after the gap on key 0.
    add_poll(4'h1, 32'd7000);
    add_poll(4'h0, 32'd7050);
    add_poll(4'h1, 32'd7400);
    add_poll(4'h0, 32'd7450);
    // Zero long threshold.
    add_cfg(REG_LONG_PRESS_MIN, 16'd0);
    add_poll(4'hF, 32'd8000);
    add_poll(4'hF, 32'd8001);
    add_poll(4'h0, 32'd8002);
    add_cfg(REG_LONG_PRESS_MIN, 16'd1000);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].idx, dir_rows[i].value);
      else send_poll(dir_rows[i].pins, dir_rows[i].now, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin sh = 20; lo = 1000; gp = 300; end
        1: begin sh = 0; lo = 1; gp = 0; end
        2: begin sh = 5; lo = 40; gp = 15; end
        3: begin sh = 65535; lo = 65535; gp = 65535; end
        4: begin
          sh = $urandom_range(0, 30);
          lo = $urandom_range(1, 300);
          gp = $urandom_range(0, 100);
        end
        5: begin sh = 0; lo = 65535; gp = 65535; end
        default: begin
          sh = $urandom_range(10, 50);
          lo = $urandom_range(60, 400);
          gp = $urandom_range(20, 200);
        end
      endcase
      write_reg(REG_SHORT_PRESS_MIN, THR_W'(sh));
      write_reg(REG_LONG_PRESS_MIN, THR_W'(lo));
      write_reg(REG_DOUBLE_GAP_MAX, THR_W'(gp));
      burst = (phase == 2);
      if (phase == 2) hold_off_req = 1'b1;
      now = (phase == 3) ? 32'hFFFF_0000 : $urandom;
      pins = '0;
      repeat (PHASE_POLLS) begin
        if (phase != 2 && $urandom_range(0, 49) == 0) burst = !burst;
        if ($urandom_range(0, 9) == 0) begin
          pins = PIN_W'($urandom);
        end else begin
          for (int k = 0; k < KEYS; k++)
            if ($urandom_range(0, 2) == 0) pins[k] = !pins[k];
        end
        sel = $urandom_range(0, 9);
        case (sel)
          0:       span = $urandom_range(0, 2);
          1, 2:    span = $urandom_range(0, sh + 1);
          3, 4:    span = $urandom_range(sh, lo);
          5:       span = $urandom_range((lo > 2) ? lo - 2 : 0, lo + 2);
          6, 7:    span = $urandom_range(0, gp + 2);
          8:       span = $urandom_range(gp, gp + 3);
          default: span = $urandom_range(0, 3000);
        endcase
        if ($urandom_range(0, 59) == 0) now = $urandom;
        else now = now + TIME_W'(span);
        send_poll(pins, now, 1'b0, '0);
      end
    end

    drain_results();
    if (mismatches == 0 && poll_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/mkcc_pkg.sv
design/mkcc_ifs.sv
design/mkcc_key.sv
design/mkcc_pick.sv
design/multi_key_click_classifier_core.sv
bench/tb_multi_key_click_classifier_core.sv
